/* rtl/ardf_pkg.sv */
// Package for the audio resampler with DC blocking and sample FIFO.
// Holds field widths, register codes, reset values and the control structs.
// No dependencies.
`default_nettype none

package ardf_pkg;

  localparam int SR_W       = 18;
  localparam int CLK_W      = 27;
  localparam int ALPHA_W    = 16;
  localparam int VOL_W      = 16;
  localparam int ACC_W      = 28;
  localparam int BIAS_W     = 18;
  localparam int SAMPLE_W   = 16;
  localparam int FILL_W     = 12;
  localparam int RC_W       = 7;
  localparam int NIB_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam logic [SR_W-1:0]    OUT_RATE_RST    = SR_W'(48000);
  localparam logic [CLK_W-1:0]   CLOCK_HZ_RST    = CLK_W'(6250000);
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = ALPHA_W'(64881);
  localparam logic [VOL_W-1:0]   VOLUME_RST      = VOL_W'(4096);

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_RATE    = 3'd0,
    CFG_CLOCK_HZ    = 3'd1,
    CFG_ALPHA       = 3'd2,
    CFG_VOLUME      = 3'd3,
    CFG_MUTE        = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SR_W-1:0]    out_rate;
    logic [CLK_W-1:0]   clock_hz;
    logic [ALPHA_W-1:0] alpha_q16;
    logic [VOL_W-1:0]   volume_q12;
    logic               mute;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic phase;
    logic bias;
    logic gain;
    logic push;
    logic setup;
    logic rd_addr;
    logic empty_load;
    logic sample_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_hit;
    logic burst_zero;
    logic burst_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/ardf_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; field widths follow the item formats.
`default_nettype none

interface ardf_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] port_byte;
  logic [6:0] read_count;

  modport source(output valid, opcode, port_byte, read_count, input ready);
  modport sink(input valid, opcode, port_byte, read_count, output ready);
endinterface

interface ardf_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               sample_valid;
  logic               last;
  logic [11:0]        fill_level;
  logic               full_flag;

  modport source(output valid, sample_out, sample_valid, last, fill_level, full_flag,
                 input ready);
  modport sink(input valid, sample_out, sample_valid, last, fill_level, full_flag,
               output ready);
endinterface

`default_nettype wire

/* rtl/audio_resample_dcblock_fifo.sv */
// Tick item: phase add alone when no sample is due, else phase add, bias
// multiply, gain multiply, saturate and store in turn when one is taken.
// Read item: an empty result if the burst is zero, else per sample a registered
// read of the store, then a result load that waits for a free output register.
// Synchronous reset clears config, accumulator, bias and FIFO pointers; the
// sample store is not cleared, and no entry is read before it is written.
`default_nettype none

module audio_resample_dcblock_fifo import ardf_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int MAX_BURST    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ardf_item_if.sink                  items,
  ardf_result_if.source              results
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      item_ready;

  ardf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ardf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (items.valid),
    .item_is_read (items.opcode == OP_READ),
    .item_ready   (item_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  assign items.ready = item_ready;

  ardf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_BURST    (MAX_BURST)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .port_byte        (items.port_byte),
    .read_count       (items.read_count),
    .res_valid        (results.valid),
    .res_ready        (results.ready),
    .res_sample       (results.sample_out),
    .res_sample_valid (results.sample_valid),
    .res_last         (results.last),
    .res_fill         (results.fill_level),
    .res_full         (results.full_flag)
  );

endmodule

`default_nettype wire

/* rtl/ardf_cfg.sv */
// Configuration register bank written through a plain write port.
// Depends on ardf_pkg for register codes and reset values.
`default_nettype none

module ardf_cfg import ardf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.out_rate    <= OUT_RATE_RST;
      regs.clock_hz    <= CLOCK_HZ_RST;
      regs.alpha_q16   <= ALPHA_RST;
      regs.volume_q12  <= VOLUME_RST;
      regs.mute        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OUT_RATE:    regs.out_rate    <= cfg_data[SR_W-1:0];
        CFG_CLOCK_HZ:    regs.clock_hz    <= cfg_data[CLK_W-1:0];
        CFG_ALPHA:       regs.alpha_q16   <= cfg_data[ALPHA_W-1:0];
        CFG_VOLUME:      regs.volume_q12  <= cfg_data[VOL_W-1:0];
        CFG_MUTE:        regs.mute        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

/* rtl/ardf_ctrl.sv */
// Controller state machine that sequences ticks and FIFO reads.
// Depends on ardf_pkg for the command and status structs.
`default_nettype none

module ardf_ctrl import ardf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  input  wire logic      item_is_read,
  output logic           item_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PHASE   = 9'b000000010,
    S_BIAS    = 9'b000000100,
    S_GAIN    = 9'b000001000,
    S_PUSH    = 9'b000010000,
    S_RDSETUP = 9'b000100000,
    S_EMPTY   = 9'b001000000,
    S_RDADDR  = 9'b010000000,
    S_RDLOAD  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = item_is_read ? S_RDSETUP : S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.phase  = 1'b1;
        state_next = sts.sample_hit ? S_BIAS : S_IDLE;
      end
      S_BIAS: begin
        cmd.bias   = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_IDLE;
      end
      S_RDSETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.burst_zero ? S_EMPTY : S_RDADDR;
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty_load = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RDADDR: begin
        cmd.rd_addr = 1'b1;
        state_next  = S_RDLOAD;
      end
      S_RDLOAD: begin
        if (sts.out_free) begin
          cmd.sample_load = 1'b1;
          state_next      = sts.burst_last ? S_IDLE : S_RDADDR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ardf_dp.sv */
// Datapath: phase accumulator, DC bias tracker, gain and saturation,
// ring FIFO memory and the result output register. Depends on ardf_pkg.
`default_nettype none

module ardf_dp import ardf_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int MAX_BURST    = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire ctrl_cmd_t           cmd,
  output ctrl_sts_t                sts,
  input  wire logic [7:0]          port_byte,
  input  wire logic [RC_W-1:0]     read_count,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic signed [SAMPLE_W-1:0] res_sample,
  output logic                     res_sample_valid,
  output logic                     res_last,
  output logic [FILL_W-1:0]        res_fill,
  output logic                     res_full
);

  localparam int CW = $clog2(BUFFER_DEPTH);
  localparam logic [CW:0]     DEPTH_C   = (CW+1)'(BUFFER_DEPTH);
  localparam logic [CW-1:0]   LAST_IDX  = CW'(BUFFER_DEPTH - 1);
  localparam logic [RC_W-1:0] BURST_MAX = RC_W'(MAX_BURST);
  localparam int CMP_W = (CW > RC_W) ? CW : RC_W;

  // Item registers.
  logic [NIB_W-1:0] nibble;
  logic [RC_W-1:0]  want;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      nibble <= port_byte[7:4];
      want   <= read_count;
    end
  end

  // Phase accumulator.
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sum;
  logic             hit;

  assign acc_sum = acc + ACC_W'(cfg.out_rate);
  assign hit     = acc_sum >= ACC_W'(cfg.clock_hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.phase) begin
      acc <= hit ? (acc_sum - ACC_W'(cfg.clock_hz)) : acc_sum;
    end
  end

  // DC bias tracker: bias = (alpha*bias + (1-alpha)*raw) >> 16.
  logic [BIAS_W-1:0] bias;
  logic [16:0]       raw;
  logic [16:0]       one_minus;
  logic [33:0]       mix_a;
  logic [20:0]       mix_b;
  logic [34:0]       mix_sum;

  assign raw       = {nibble, 13'b0};
  assign one_minus = 17'h10000 - 17'(cfg.alpha_q16);
  assign mix_a     = 34'(cfg.alpha_q16) * 34'(bias);
  assign mix_b     = 21'(one_minus) * 21'(nibble);
  assign mix_sum   = 35'(mix_a) + 35'({mix_b, 13'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cmd.bias) begin
      bias <= mix_sum[33:16];
    end
  end

  // Gain: (raw - bias) * volume, registered before scaling.
  logic signed [18:0] diff;
  logic signed [35:0] prod;

  assign diff = signed'({2'b00, raw}) - signed'({1'b0, bias});

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      prod <= 36'(diff) * 36'(signed'({1'b0, cfg.volume_q12}));
    end
  end

  // Shift toward zero, saturate to Q1.15, then mute.
  logic [35:0]         mag;
  logic [22:0]         shifted;
  logic [SAMPLE_W-1:0] conditioned;

  assign mag     = prod[35] ? 36'(-prod) : 36'(prod);
  assign shifted = mag[35:13];

  always_comb begin
    if (!prod[35]) begin
      conditioned = (shifted > 23'd32767) ? 16'h7FFF : shifted[15:0];
    end else begin
      conditioned = (shifted > 23'd32768) ? 16'h8000 : ((~shifted[15:0]) + 16'd1);
    end
    if (cfg.mute) begin
      conditioned = '0;
    end
  end

  // Ring FIFO pointers and occupancy.
  logic [CW-1:0] wptr, rptr;
  logic [CW-1:0] wptr_inc, rptr_inc;
  logic [CW:0]   count_wide;
  logic [CW-1:0] count;
  logic          full;

  assign wptr_inc   = (wptr == LAST_IDX) ? '0 : wptr + 1'b1;
  assign rptr_inc   = (rptr == LAST_IDX) ? '0 : rptr + 1'b1;
  assign full       = wptr_inc == rptr;
  assign count_wide = (wptr >= rptr) ? ({1'b0, wptr} - {1'b0, rptr})
                                     : (DEPTH_C - {1'b0, rptr} + {1'b0, wptr});
  assign count      = count_wide[CW-1:0];

  logic wr_en;
  assign wr_en = cmd.push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr_inc;
      end
      if (cmd.rd_addr) begin
        rptr <= rptr_inc;
      end
    end
  end

  // Sample store.
  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= conditioned;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_addr) begin
      rdata <= mem[rptr];
    end
  end

  // Burst length: the request limited to the burst maximum and the fill.
  logic [RC_W-1:0] want_sat;
  logic [RC_W-1:0] burst_len;
  logic [RC_W-1:0] remaining;

  assign want_sat  = (want > BURST_MAX) ? BURST_MAX : want;
  assign burst_len = (CMP_W'(count) < CMP_W'(want_sat)) ? RC_W'(count) : want_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.setup) begin
      remaining <= burst_len;
    end else if (cmd.sample_load) begin
      remaining <= remaining - 1'b1;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.empty_load || cmd.sample_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.empty_load) begin
      res_sample       <= '0;
      res_sample_valid <= 1'b0;
      res_last         <= 1'b1;
      res_fill         <= FILL_W'(count);
      res_full         <= full;
    end else if (cmd.sample_load) begin
      res_sample       <= signed'(rdata);
      res_sample_valid <= 1'b1;
      res_last         <= remaining == RC_W'(1);
      res_fill         <= FILL_W'(count);
      res_full         <= full;
    end
  end

  assign sts = '{sample_hit: hit,
                 burst_zero: (burst_len == '0),
                 burst_last: (remaining == RC_W'(1)),
                 out_free:   (!res_valid || res_ready)};

endmodule

`default_nettype wire
